// File: design/ifdf_pkg.sv
package ifdf_pkg;

   localparam int DIM_W = 11;
   localparam int PIX_W = 21;
   localparam int LEN_W = 22;
   localparam int ROW_W = 10;

   localparam logic [DIM_W-1:0] MAX_WIDTH  = 11'd1024;
   localparam logic [DIM_W-1:0] MAX_HEIGHT = 11'd1024;
   localparam logic [LEN_W-1:0] LEN_MAX    = 22'h3FFFFF;
   localparam logic [31:0]      START_MARK = 32'h48414C46;
   localparam logic [31:0]      END_MARK   = 32'h464C4148;

   typedef enum logic [1:0] {
      KIND_IMAGE   = 2'd0,
      KIND_OVERLAY = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      FMT_MONO = 2'd0,
      FMT_GRAY = 2'd1,
      FMT_RGB  = 2'd2
   } format_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_FORMAT = 2'd2,
      CSR_LINES  = 2'd3
   } csr_index_type;

   // One decoded payload or frame-end word handed from the parser to the result stage.
   typedef struct packed {
      kind_type         kind;
      logic             mono;
      logic [7:0]       data;
      logic [LEN_W-1:0] index;
      logic [1:0]       line;
      logic [ROW_W-1:0] row;
      logic [LEN_W-1:0] plen;
   } desc_type;

endpackage

// File: design/ifdf_chan_if.sv
interface ifdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ifdf_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [7:0]        pixel_value;
   logic [21:0]       element_index;
   logic [1:0]        line_number;
   logic [9:0]        row;
   logic signed [7:0] line_x;
   logic [21:0]       payload_length;
   logic              last;

   modport source (output valid, output kind, output pixel_value, output element_index,
                   output line_number, output row, output line_x,
                   output payload_length, output last, input ready);
   modport sink   (input valid, input kind, input pixel_value, input element_index,
                   input line_number, input row, input line_x,
                   input payload_length, input last, output ready);
endinterface

// File: design/image_frame_deframer_core.sv
// Frame deframer: hunts the byte stream for the start marker 48 41 4C 46,
// then passes payload through a four-byte delay line until the end marker
// 46 4C 41 48, so a payload byte yields its result only once three more bytes
// have arrived. Each byte is registered in the input register and its
// result is loaded into the output register once the result stage can take
// it; rsp valid comes straight from that output register. Gray, RGB, overlay
// and frame-end words take one byte per clock while rsp ready stays high; in
// mono format each image byte becomes eight pixel words delivered one per clock
// from the single result register while rsp ready stays high. Configuration
// is picked up by the next byte; it is to be written only while the block is
// idle, which the block itself does not enforce. No clearing pass follows reset.
module image_frame_deframer_core import ifdf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ifdf_req_if.sink         req_ch,
   ifdf_rsp_if.source       rsp_ch,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);

   logic     desc_vld;
   desc_type desc;
   logic     emit_ready;

   ifdf_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .desc_vld   (desc_vld),
      .desc       (desc),
      .emit_ready (emit_ready)
   );

   ifdf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .desc_vld   (desc_vld),
      .desc       (desc),
      .emit_ready (emit_ready),
      .rsp_ch     (rsp_ch)
   );

   // a mono burst steps the pixel index by one each word
   a_burst_step: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last
      |=> rsp_ch.valid && rsp_ch.element_index == $past(rsp_ch.element_index) + 22'd1)
      else $error("mono burst index did not advance");

   // a non-final word of a burst is always an expanded mono pixel
   a_burst_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.last
      |-> rsp_ch.kind == KIND_IMAGE && (rsp_ch.pixel_value == 8'd0 ||
          rsp_ch.pixel_value == 8'd255))
      else $error("partial burst on a non-mono word");

   // a decoded word waiting on the result stage holds
   a_desc_hold: assert property (@(posedge clock) disable iff (reset)
      desc_vld && !emit_ready |=> desc_vld && $stable(desc))
      else $error("decoded word changed while stalled");

endmodule

// File: design/ifdf_parse.sv
module ifdf_parse import ifdf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ifdf_req_if.sink         req_ch,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [DIM_W-1:0] csr_wdata,
   output logic             desc_vld,
   output desc_type         desc,
   input  logic             emit_ready
);

   logic [DIM_W-1:0] width_ff, height_ff;
   format_type       format_ff;
   logic [1:0]       lines_ff;
   logic [PIX_W-1:0] pix_ff, pix_in;

   logic             in_vld_ff;
   logic [7:0]       in_byte_ff;

   logic             frame_ff, frame_in;
   logic [31:0]      win_ff, win_in;
   logic [2:0]       fill_ff, fill_in;
   logic [LEN_W-1:0] off_ff, off_in;
   logic [1:0]       line_ff, line_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [DIM_W-1:0] w_c, h_c;
   logic [LEN_W-1:0] img_len;
   logic [31:0]      win_shift;
   logic [2:0]       fill_inc;
   logic             hit;
   logic             proc;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd128;
         height_ff <= 11'd64;
         format_ff <= FMT_GRAY;
         lines_ff  <= 2'd0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_FORMAT: format_ff <= format_type'(csr_wdata[1:0]);
            CSR_LINES:  lines_ff  <= csr_wdata[1:0];
            default:    ;
         endcase
      end
   end

   assign w_c    = (width_ff > MAX_WIDTH) ? MAX_WIDTH : width_ff;
   assign h_c    = (height_ff > MAX_HEIGHT) ? MAX_HEIGHT : height_ff;
   assign pix_in = PIX_W'(w_c) * PIX_W'(h_c);

   // The pixel count is registered from the clamped width and height, so it lags
   // a register write; a byte processed before it catches up sees the old product.
   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   always_comb begin
      case (format_ff)
         FMT_MONO: img_len = {4'd0, pix_ff[PIX_W-1:3]};
         FMT_RGB:  img_len = {1'b0, pix_ff} + {pix_ff, 1'b0};
         default:  img_len = {1'b0, pix_ff};
      endcase
   end

   assign win_shift = {win_ff[23:0], in_byte_ff};
   assign fill_inc  = (fill_ff == 3'd4) ? 3'd4 : fill_ff + 3'd1;

   always_comb begin
      win_in   = win_shift;
      fill_in  = fill_inc;
      frame_in = frame_ff;
      off_in   = off_ff;
      line_in  = line_ff;
      row_in   = row_ff;
      hit      = 1'b0;
      desc     = '0;
      if (!frame_ff) begin
         if (fill_inc == 3'd4 && win_shift == START_MARK) begin
            frame_in = 1'b1;
            win_in   = '0;
            fill_in  = '0;
            off_in   = '0;
            line_in  = '0;
            row_in   = '0;
         end
      end else if (fill_inc == 3'd4) begin
         if (win_shift == END_MARK) begin
            hit       = 1'b1;
            desc.kind = KIND_END;
            desc.plen = off_ff;
            frame_in  = 1'b0;
            win_in    = '0;
            fill_in   = '0;
            off_in    = '0;
            line_in   = '0;
            row_in    = '0;
         end else begin
            // release the oldest byte of the window as payload
            win_in  = {8'd0, win_shift[23:0]};
            fill_in = 3'd3;
            if (off_ff != LEN_MAX) begin
               off_in = off_ff + 22'd1;
               if (off_ff < img_len) begin
                  hit        = 1'b1;
                  desc.kind  = KIND_IMAGE;
                  desc.mono  = (format_ff == FMT_MONO);
                  desc.data  = win_shift[31:24];
                  desc.index = off_ff;
               end else if (h_c != '0 && line_ff < lines_ff) begin
                  hit       = 1'b1;
                  desc.kind = KIND_OVERLAY;
                  desc.data = win_shift[31:24];
                  desc.line = line_ff;
                  desc.row  = row_ff;
                  if ({1'b0, row_ff} + 11'd1 == h_c) begin
                     row_in  = '0;
                     line_in = line_ff + 2'd1;
                  end else begin
                     row_in = row_ff + 10'd1;
                  end
               end
            end
         end
      end
   end

   // a word that yields no result never waits on the result stage
   assign proc         = in_vld_ff && (emit_ready || !hit);
   assign desc_vld     = in_vld_ff && hit;
   assign req_ch.ready = !in_vld_ff || proc;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         frame_ff  <= 1'b0;
         win_ff    <= '0;
         fill_ff   <= '0;
         off_ff    <= '0;
         line_ff   <= '0;
         row_ff    <= '0;
      end else begin
         if (req_ch.ready) begin
            in_vld_ff <= req_ch.valid;
         end
         if (proc) begin
            frame_ff <= frame_in;
            win_ff   <= win_in;
            fill_ff  <= fill_in;
            off_ff   <= off_in;
            line_ff  <= line_in;
            row_ff   <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.data_byte;
      end
   end

endmodule

// File: design/ifdf_emit.sv
module ifdf_emit import ifdf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      desc_vld,
   input  desc_type  desc,
   output logic      emit_ready,
   ifdf_rsp_if.source rsp_ch
);

   logic     out_vld_ff;
   desc_type hold_ff;
   logic [2:0] cnt_ff;
   logic     last_c;

   assign last_c     = !hold_ff.mono || cnt_ff == 3'd7;
   assign emit_ready = !out_vld_ff || (rsp_ch.ready && last_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         cnt_ff     <= '0;
      end else if (desc_vld && emit_ready) begin
         out_vld_ff <= 1'b1;
         cnt_ff     <= '0;
      end else if (out_vld_ff && rsp_ch.ready) begin
         // advance through a mono burst, drop the word after its last pixel
         if (last_c) begin
            out_vld_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (desc_vld && emit_ready) begin
         hold_ff <= desc;
      end
   end

   always_comb begin
      rsp_ch.valid          = out_vld_ff;
      rsp_ch.kind           = hold_ff.kind;
      rsp_ch.pixel_value    = 8'd0;
      rsp_ch.element_index  = '0;
      rsp_ch.line_x         = 8'sd0;
      rsp_ch.line_number    = hold_ff.line;
      rsp_ch.row            = hold_ff.row;
      rsp_ch.payload_length = hold_ff.plen;
      rsp_ch.last           = last_c;
      if (hold_ff.kind == KIND_IMAGE) begin
         if (hold_ff.mono) begin
            rsp_ch.pixel_value   = {8{hold_ff.data[3'd7 - cnt_ff]}};
            rsp_ch.element_index = {hold_ff.index[LEN_W-4:0], cnt_ff};
         end else begin
            rsp_ch.pixel_value   = hold_ff.data;
            rsp_ch.element_index = hold_ff.index;
         end
      end
      if (hold_ff.kind == KIND_OVERLAY) begin
         rsp_ch.line_x = signed'(hold_ff.data);
      end
   end

endmodule

// File: verif/tb_image_frame_deframer_core.sv
`timescale 1ns / 100ps

import ifdf_pkg::*;

typedef struct packed {
   kind_type          kind;
   logic [7:0]        pix;
   logic [LEN_W-1:0]  idx;
   logic [1:0]        line;
   logic [ROW_W-1:0]  row;
   logic signed [7:0] x;
   logic [LEN_W-1:0]  plen;
   logic              last;
} deframe_word_type;

class frame_tracker;
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   logic [1:0]       fmt_reg;
   logic [1:0]       lines_reg;
   bit               framing;
   logic [31:0]      window;
   int               fill;
   logic [LEN_W-1:0] offset;
   deframe_word_type pending_words[$];
   int               errors;
   int               n_image;
   int               n_overlay;
   int               n_end;

   function new();
      width_reg  = 11'd128;
      height_reg = 11'd64;
      fmt_reg    = FMT_GRAY;
      lines_reg  = 2'd0;
      framing    = 1'b0;
      window     = '0;
      fill       = 0;
      offset     = '0;
      errors     = 0;
      n_image    = 0;
      n_overlay  = 0;
      n_end      = 0;
   endfunction

   function void add_word(deframe_word_type wd);
      pending_words.insert(pending_words.size(), wd);
   endfunction

   function void set_reg(csr_index_type sel, logic [DIM_W-1:0] val);
      case (sel)
         CSR_WIDTH:  width_reg  = val;
         CSR_HEIGHT: height_reg = val;
         CSR_FORMAT: fmt_reg    = val[1:0];
         CSR_LINES:  lines_reg  = val[1:0];
         default: ;
      endcase
   endfunction

   // Split one released payload byte into image elements or overlay points.
   function void take_payload(logic [7:0] b);
      longint           w;
      longint           h;
      longint           img;
      longint           o;
      longint           rel;
      longint           nlines;
      deframe_word_type wd;
      if (offset >= LEN_MAX) return;
      w      = longint'((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h      = longint'((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
      nlines = longint'(lines_reg);
      o      = longint'(offset);
      offset = offset + 22'd1;
      if (fmt_reg == FMT_MONO)
         img = (w * h) >> 3;
      else if (fmt_reg == FMT_RGB)
         img = w * h * 3;
      else
         img = w * h;
      if (o < img) begin
         if (fmt_reg == FMT_MONO) begin
            // expand MSB first
            for (int i = 0; i < 8; i++) begin
               wd      = '0;
               wd.kind = KIND_IMAGE;
               wd.pix  = b[7-i] ? 8'hFF : 8'h00;
               wd.idx  = LEN_W'(o * 8 + i);
               wd.last = (i == 7);
               add_word(wd);
            end
         end else begin
            wd      = '0;
            wd.kind = KIND_IMAGE;
            wd.pix  = b;
            wd.idx  = LEN_W'(o);
            wd.last = 1'b1;
            add_word(wd);
         end
      end else if (h != 0) begin
         rel = o - img;
         if (rel < nlines * h) begin
            wd      = '0;
            wd.kind = KIND_OVERLAY;
            wd.line = 2'(rel / h);
            wd.row  = ROW_W'(rel % h);
            wd.x    = b;
            wd.last = 1'b1;
            add_word(wd);
         end
      end
   endfunction

   function void take_byte(logic [7:0] b);
      logic [7:0]       oldest;
      deframe_word_type wd;
      window = {window[23:0], b};
      if (fill < 4) fill++;
      if (!framing) begin
         if (fill == 4 && window == START_MARK) begin
            framing = 1'b1;
            window  = '0;
            fill    = 0;
            offset  = '0;
         end
      end else if (fill == 4) begin
         if (window == END_MARK) begin
            wd      = '0;
            wd.kind = KIND_END;
            wd.plen = offset;
            wd.last = 1'b1;
            add_word(wd);
            framing = 1'b0;
            window  = '0;
            fill    = 0;
            offset  = '0;
         end else begin
            // release the oldest byte of the delay line
            oldest        = window[31:24];
            window[31:24] = 8'h00;
            fill          = 3;
            take_payload(oldest);
         end
      end
   endfunction

   function string show(deframe_word_type w);
      return $sformatf("kind=%0d pix=%0d idx=%0d line=%0d row=%0d x=%0d plen=%0d last=%0d",
                       w.kind, w.pix, w.idx, w.line, w.row, w.x, w.plen, w.last);
   endfunction

   function void match_word(deframe_word_type got);
      deframe_word_type want;
      bit               bad;
      if (pending_words.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected word: %s", show(got));
         return;
      end
      want = pending_words[0];
      pending_words.delete(0);
      bad = (got.kind !== want.kind) || (got.pix !== want.pix) || (got.idx !== want.idx) ||
            (got.line !== want.line) || (got.row !== want.row) || (got.x !== want.x) ||
            (got.plen !== want.plen) || (got.last !== want.last);
      if (bad) begin
         errors++;
         if (errors <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
         end
      end
      case (want.kind)
         KIND_IMAGE:   n_image++;
         KIND_OVERLAY: n_overlay++;
         default:      n_end++;
      endcase
   endfunction
endclass

module tb_image_frame_deframer_core;

   localparam int         WATCHDOG_LIMIT = 3000;
   localparam int         DRAIN_CYCLES   = 16;
   localparam int         PHASE_BYTES    = 26;
   localparam int         TARGET_CAP     = 40;
   localparam logic [1:0] FMT_UNUSED     = 2'd3;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [DIM_W-1:0] csr_wdata;
   bit               calm;
   int               stall_cycles;
   int               bytes_sent;
   int               frames_sent;
   int               settings_seen;

   ifdf_req_if req_bus();
   ifdf_rsp_if rsp_bus();

   frame_tracker book = new();

   image_frame_deframer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 9);
   end

   always @(posedge clock) begin
      deframe_word_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.kind = kind_type'(rsp_bus.kind);
         got.pix  = rsp_bus.pixel_value;
         got.idx  = rsp_bus.element_index;
         got.line = rsp_bus.line_number;
         got.row  = rsp_bus.row;
         got.x    = rsp_bus.line_x;
         got.plen = rsp_bus.payload_length;
         got.last = rsp_bus.last;
         book.match_word(got);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles, %0d still expected",
                  stall_cycles, book.pending_words.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(0, 99) < 9) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      book.take_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_marker(input logic [31:0] m);
      for (int k = 0; k < 4; k++) send_byte(m[31-8*k -: 8]);
   endtask

   // Hold the sender until every expected word is out, then let the block go quiet.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (book.pending_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type sel, input logic [DIM_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(posedge clock);
      book.set_reg(sel, val);
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [1:0] f, input logic [1:0] l);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_FORMAT, {9'd0, f});
      write_reg(CSR_LINES, {9'd0, l});
      csr_we <= 1'b0;
      settings_seen++;
   endtask

   task automatic send_noise();
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
      // broken start marker
      if ($urandom_range(0, 7) == 0)
         for (int k = 0; k < $urandom_range(1, 3); k++) send_byte(START_MARK[31-8*k -: 8]);
   endtask

   task automatic send_frame(input int target, output int sent);
      int pick;
      int len;
      pick = $urandom_range(0, 9);
      if (pick < 6)
         len = target + $urandom_range(0, 2);
      else if (pick < 8)
         len = $urandom_range(0, target);
      else
         len = $urandom_range(0, TARGET_CAP);
      send_marker(START_MARK);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
      send_marker(END_MARK);
      frames_sent++;
      sent = len + 8;
      // tail of a start marker right after the end marker must not reopen
      if ($urandom_range(0, 5) == 0) begin
         send_byte(START_MARK[23:16]);
         send_byte(START_MARK[15:8]);
         send_byte(START_MARK[7:0]);
      end
   endtask

   task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic [1:0] f, input logic [1:0] l, input bit quiet);
      int cw;
      int ch;
      int target;
      int filled;
      int got;
      settle();
      apply_setting(w, h, f, l);
      calm   = quiet;
      cw     = int'((w > MAX_WIDTH) ? MAX_WIDTH : w);
      ch     = int'((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
      if (f == FMT_MONO)
         target = (cw * ch) / 8;
      else if (f == FMT_RGB)
         target = cw * ch * 3;
      else
         target = cw * ch;
      target = target + int'(l) * ch;
      if (target > TARGET_CAP) target = TARGET_CAP;
      filled = 0;
      while (filled < PHASE_BYTES) begin
         send_noise();
         send_frame(target, got);
         filled += got;
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      rsp_bus.ready     = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_WIDTH;
      csr_wdata         = '0;
      calm              = 1'b0;
      stall_cycles      = 0;
      bytes_sent        = 0;
      frames_sent       = 0;
      settings_seen     = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 2x2 gray, one overlay line: image, overlay extremes, one excess byte
      apply_setting(11'd2, 11'd2, FMT_GRAY, 2'd1);
      send_marker(START_MARK);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(8'h55);
      send_marker(END_MARK);
      // start marker's last byte must not count toward the end marker
      send_marker(START_MARK);
      send_byte(END_MARK[23:16]);
      send_byte(END_MARK[15:8]);
      send_byte(END_MARK[7:0]);
      send_marker(END_MARK);
      frames_sent += 2;

      run_phase(11'd1, 11'd1, FMT_MONO, 2'd3, 1'b0);
      run_phase(11'd8, 11'd2, FMT_MONO, 2'd2, 1'b0);
      run_phase(11'd3, 11'd2, FMT_RGB, 2'd3, 1'b1);
      run_phase(11'd1024, 11'd1024, FMT_GRAY, 2'd0, 1'b0);
      run_phase(11'd2047, 11'd2047, FMT_UNUSED, 2'd3, 1'b0);
      run_phase(11'd0, 11'd5, FMT_GRAY, 2'd2, 1'b0);
      run_phase(11'd5, 11'd0, FMT_RGB, 2'd3, 1'b0);
      run_phase(11'd1, 11'd1024, FMT_RGB, 2'd1, 1'b0);
      run_phase(11'd16, 11'd3, FMT_MONO, 2'd1, 1'b0);
      settle();

      $display("sent %0d bytes in %0d frames over %0d register settings",
               bytes_sent, frames_sent, settings_seen);
      $display("checked %0d image, %0d overlay and %0d frame-end words, %0d mismatches",
               book.n_image, book.n_overlay, book.n_end, book.errors);
      if (book.errors == 0 && book.pending_words.size() == 0)
         $display("TEST PASSED");
      else begin
         $display("%0d words never arrived", book.pending_words.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
